// ===== design/llfc_pkg.sv =====
// ---------------------------------------------------------------------------
// llfc_pkg: line-line fillet center shared types
// Beat structs, status codes and pipeline step counts.
// ---------------------------------------------------------------------------
package llfc_pkg;

	localparam int SQ_STEPS = 32;   // root bits of the length square root
	localparam int DIR_STEPS = 31;  // quotient bits of a unit component
	localparam int CQ_STEPS = 31;   // quotient bits of a center coordinate
	localparam int NCAND = 4;
	localparam int NLANE = 2 * NCAND;

	localparam logic [1:0] STATUS_FOUND = 2'd0;
	localparam logic [1:0] STATUS_NONE = 2'd1;
	localparam logic [1:0] STATUS_DEGEN = 2'd2;

	typedef struct packed {
		logic signed [31:0] line_a_start_x;
		logic signed [31:0] line_a_start_y;
		logic signed [31:0] line_a_end_x;
		logic signed [31:0] line_a_end_y;
		logic signed [31:0] line_b_start_x;
		logic signed [31:0] line_b_start_y;
		logic signed [31:0] line_b_end_x;
		logic signed [31:0] line_b_end_y;
		logic [30:0] fillet_radius;
		logic a_corner_at_start;
		logic b_corner_at_start;
	} query_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] tangent_a_x;
		logic signed [31:0] tangent_a_y;
		logic signed [31:0] tangent_b_x;
		logic signed [31:0] tangent_b_y;
	} result_t;

	// per-item context that rides along the whole pipe
	typedef struct packed {
		logic ok;
		logic signed [31:0] cax;
		logic signed [31:0] cay;
		logic signed [31:0] cbx;
		logic signed [31:0] cby;
		logic [30:0] rad;
		logic [3:0] sgn;
		logic [3:0][30:0] u;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [61:0] dmag;
		logic dneg;
		logic found;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [39:0] da;
		logic signed [39:0] db;
	} ctx_t;

endpackage

// ===== design/line_line_fillet_center_top.sv =====
// ---------------------------------------------------------------------------
// line_line_fillet_center_top: fillet arc center of two line segments
// Fully pipelined Q16.16 solver: unit directions, four offset-line
// intersections, forward test, tangent points.
// ---------------------------------------------------------------------------
// Throughput: one query beat per cycle while the result is not stalled; the 32-step root,
// the two 31-step restoring dividers and the wide multiplier stages are all unrolled.
// A stalled result freezes the whole pipe (ready = !result_valid | result_ready).
// Reset clears the valid bits only; data registers are not reset.
module line_line_fillet_center_top import llfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_ready,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = v[32] ? -v : v;
		return n[31:0];
	endfunction

	// scale both magnitudes by one power of two so the larger is in [2^30, 2^31)
	function automatic logic [61:0] norm_pair(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] m;
		logic [31:0] xs;
		logic [31:0] ys;
		int s;
		m = (x > y) ? x : y;
		xs = x;
		ys = y;
		if (m[31]) begin
			xs = x >> 1;
			ys = y >> 1;
		end else begin
			for (int i = 4; i >= 0; i--) begin
				s = 1 << i;
				if (m < (32'd1 << (31 - s))) begin
					m = m << s;
					xs = xs << s;
					ys = ys << s;
				end
			end
		end
		return {xs[30:0], ys[30:0]};
	endfunction

	// round v / 2^30 to nearest, ties away from zero
	function automatic logic signed [51:0] rnd_q30(input logic signed [79:0] v);
		logic [79:0] m;
		logic [80:0] s;
		logic [50:0] q;
		m = v[79] ? 80'(-v) : 80'(v);
		s = 81'(m) + (81'd1 << 29);
		q = s[80:30];
		return v[79] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		if (v > 53'sd2147483647) return 32'sh7FFF_FFFF;
		else if (v < -53'sd2147483648) return 32'sh8000_0000;
		else return v[31:0];
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;

	// whole pipe moves together; a held result holds every stage
	assign adv = !v_s18 || result_ready;
	assign query_ready = adv;

	// -----------------------------------------------------------------------
	// s1: pick corners, difference vectors, normalize magnitudes
	// -----------------------------------------------------------------------
	ctx_t ctx_n1, ctx_s1;
	always_comb begin
		logic signed [31:0] oax, oay, obx, oby;
		logic signed [32:0] dax, day, dbx, dby;
		logic [61:0] na, nb;
		ctx_n1 = '0;
		if (query.a_corner_at_start) begin
			ctx_n1.cax = query.line_a_start_x;
			ctx_n1.cay = query.line_a_start_y;
			oax = query.line_a_end_x;
			oay = query.line_a_end_y;
		end else begin
			ctx_n1.cax = query.line_a_end_x;
			ctx_n1.cay = query.line_a_end_y;
			oax = query.line_a_start_x;
			oay = query.line_a_start_y;
		end
		if (query.b_corner_at_start) begin
			ctx_n1.cbx = query.line_b_start_x;
			ctx_n1.cby = query.line_b_start_y;
			obx = query.line_b_end_x;
			oby = query.line_b_end_y;
		end else begin
			ctx_n1.cbx = query.line_b_end_x;
			ctx_n1.cby = query.line_b_end_y;
			obx = query.line_b_start_x;
			oby = query.line_b_start_y;
		end
		dax = 33'(oax) - 33'(ctx_n1.cax);
		day = 33'(oay) - 33'(ctx_n1.cay);
		dbx = 33'(obx) - 33'(ctx_n1.cbx);
		dby = 33'(oby) - 33'(ctx_n1.cby);
		na = norm_pair(mag33(dax), mag33(day));
		nb = norm_pair(mag33(dbx), mag33(dby));
		ctx_n1.u[0] = na[61:31];
		ctx_n1.u[1] = na[30:0];
		ctx_n1.u[2] = nb[61:31];
		ctx_n1.u[3] = nb[30:0];
		ctx_n1.sgn = {dby[32], dbx[32], day[32], dax[32]};
		ctx_n1.ok = (dax != 0 || day != 0) && (dbx != 0 || dby != 0);
		ctx_n1.rad = query.fillet_radius;
	end

	always_ff @(posedge clk) begin
		if (adv) ctx_s1 <= ctx_n1;
	end

	// s2: squared length of each normalized direction
	ctx_t ctx_s2;
	logic [62:0] sumsq_s2 [2];
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2 <= ctx_s1;
			for (int l = 0; l < 2; l++) begin
				sumsq_s2[l] <= 63'(ctx_s1.u[2*l]) * 63'(ctx_s1.u[2*l]) +
					63'(ctx_s1.u[2*l+1]) * 63'(ctx_s1.u[2*l+1]);
			end
		end
	end

	// -----------------------------------------------------------------------
	// square root, one root bit per stage, both lines side by side
	// -----------------------------------------------------------------------
	ctx_t        sq_ctx_s  [SQ_STEPS];
	logic        sq_v_s    [SQ_STEPS];
	logic [63:0] sq_val_s  [SQ_STEPS][2];
	logic [33:0] sq_rem_s  [SQ_STEPS][2];
	logic [31:0] sq_root_s [SQ_STEPS][2];

	for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sq
		ctx_t        c_in;
		logic        v_in;
		logic [63:0] val_in [2];
		logic [33:0] rem_in [2];
		logic [31:0] root_in [2];
		logic [63:0] val_n [2];
		logic [33:0] rem_n [2];
		logic [31:0] root_n [2];

		if (gi == 0) begin : g_first
			always_comb begin
				c_in = ctx_s2;
				v_in = v_s2;
				for (int l = 0; l < 2; l++) begin
					val_in[l] = {1'b0, sumsq_s2[l]};
					rem_in[l] = '0;
					root_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				c_in = sq_ctx_s[gi-1];
				v_in = sq_v_s[gi-1];
				for (int l = 0; l < 2; l++) begin
					val_in[l] = sq_val_s[gi-1][l];
					rem_in[l] = sq_rem_s[gi-1][l];
					root_in[l] = sq_root_s[gi-1][l];
				end
			end
		end

		always_comb begin
			logic [35:0] r2;
			logic [33:0] t;
			for (int l = 0; l < 2; l++) begin
				r2 = {rem_in[l], val_in[l][63:62]};
				t = {root_in[l], 2'b01};
				if (r2 >= {2'b00, t}) begin
					rem_n[l] = 34'(r2 - {2'b00, t});
					root_n[l] = {root_in[l][30:0], 1'b1};
				end else begin
					rem_n[l] = r2[33:0];
					root_n[l] = {root_in[l][30:0], 1'b0};
				end
				val_n[l] = val_in[l] << 2;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[gi] <= 1'b0;
			else if (adv) sq_v_s[gi] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx_s[gi] <= c_in;
				for (int l = 0; l < 2; l++) begin
					sq_val_s[gi][l] <= val_n[l];
					sq_rem_s[gi][l] <= rem_n[l];
					sq_root_s[gi][l] <= root_n[l];
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// unit components: (u << 30) / len, one quotient bit per stage
	// -----------------------------------------------------------------------
	ctx_t        du_ctx_s [DIR_STEPS];
	logic        du_v_s   [DIR_STEPS];
	logic [31:0] du_len_s [DIR_STEPS][2];
	logic [31:0] du_r_s   [DIR_STEPS][4];
	logic [30:0] du_q_s   [DIR_STEPS][4];

	for (genvar gi = 0; gi < DIR_STEPS; gi++) begin : g_du
		ctx_t        c_in;
		logic        v_in;
		logic [31:0] len_in [2];
		logic [31:0] r_in [4];
		logic [30:0] q_in [4];
		logic        b_in [4];
		logic [31:0] r_n [4];
		logic [30:0] q_n [4];

		if (gi == 0) begin : g_first
			always_comb begin
				c_in = sq_ctx_s[SQ_STEPS-1];
				v_in = sq_v_s[SQ_STEPS-1];
				for (int l = 0; l < 2; l++) len_in[l] = sq_root_s[SQ_STEPS-1][l];
				for (int c = 0; c < 4; c++) begin
					r_in[c] = {2'b00, c_in.u[c][30:1]};
					q_in[c] = '0;
					b_in[c] = c_in.u[c][0];
				end
			end
		end else begin : g_next
			always_comb begin
				c_in = du_ctx_s[gi-1];
				v_in = du_v_s[gi-1];
				for (int l = 0; l < 2; l++) len_in[l] = du_len_s[gi-1][l];
				for (int c = 0; c < 4; c++) begin
					r_in[c] = du_r_s[gi-1][c];
					q_in[c] = du_q_s[gi-1][c];
					b_in[c] = 1'b0;
				end
			end
		end

		always_comb begin
			logic [32:0] r2;
			for (int c = 0; c < 4; c++) begin
				r2 = {r_in[c], b_in[c]};
				if (r2 >= {1'b0, len_in[c/2]}) begin
					r_n[c] = 32'(r2 - {1'b0, len_in[c/2]});
					q_n[c] = {q_in[c][29:0], 1'b1};
				end else begin
					r_n[c] = r2[31:0];
					q_n[c] = {q_in[c][29:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) du_v_s[gi] <= 1'b0;
			else if (adv) du_v_s[gi] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				du_ctx_s[gi] <= c_in;
				for (int l = 0; l < 2; l++) du_len_s[gi][l] <= len_in[l];
				for (int c = 0; c < 4; c++) begin
					du_r_s[gi][c] <= r_n[c];
					du_q_s[gi][c] <= q_n[c];
				end
			end
		end
	end

	// s3: signed Q2.30 unit directions
	ctx_t ctx_n3, ctx_s3;
	always_comb begin
		logic signed [31:0] uv [4];
		ctx_n3 = du_ctx_s[DIR_STEPS-1];
		for (int c = 0; c < 4; c++) begin
			uv[c] = $signed({1'b0, du_q_s[DIR_STEPS-1][c]});
			if (ctx_n3.sgn[c]) uv[c] = -uv[c];
		end
		ctx_n3.ax = uv[0];
		ctx_n3.ay = uv[1];
		ctx_n3.bx = uv[2];
		ctx_n3.by = uv[3];
	end

	always_ff @(posedge clk) begin
		if (adv) ctx_s3 <= ctx_n3;
	end

	// s4: determinant and normal-offset products
	ctx_t ctx_s4;
	logic signed [63:0] p_axby_s4, p_aybx_s4, p_aycax_s4, p_axcay_s4, p_bycbx_s4, p_bxcby_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4 <= ctx_s3;
			p_axby_s4 <= ctx_s3.ax * ctx_s3.by;
			p_aybx_s4 <= ctx_s3.ay * ctx_s3.bx;
			p_aycax_s4 <= ctx_s3.ay * ctx_s3.cax;
			p_axcay_s4 <= ctx_s3.ax * ctx_s3.cay;
			p_bycbx_s4 <= ctx_s3.by * ctx_s3.cbx;
			p_bxcby_s4 <= ctx_s3.bx * ctx_s3.cby;
		end
	end

	// s5: det, line values na, nb
	ctx_t ctx_n5, ctx_s5;
	logic signed [63:0] na_s5, nb_s5;
	always_comb begin
		logic signed [63:0] det;
		ctx_n5 = ctx_s4;
		det = p_axby_s4 - p_aybx_s4;
		ctx_n5.dneg = det[63];
		ctx_n5.dmag = det[63] ? 62'(-det) : det[61:0];
		ctx_n5.ok = ctx_s4.ok && (det != 0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5 <= ctx_n5;
			na_s5 <= p_axcay_s4 - p_aycax_s4;
			nb_s5 <= p_bxcby_s4 - p_bycbx_s4;
		end
	end

	// s6: partial products of the numerators, per axis (0: x, 1: y)
	ctx_t ctx_s6;
	logic signed [63:0] ph_s6 [2], qh_s6 [2], rb_s6 [2], ra_s6 [2];
	logic signed [64:0] pl_s6 [2], ql_s6 [2];
	always_ff @(posedge clk) begin
		logic signed [31:0] pc [2];
		logic signed [31:0] qc [2];
		if (adv) begin
			pc[0] = ctx_s5.bx;
			pc[1] = ctx_s5.by;
			qc[0] = ctx_s5.ax;
			qc[1] = ctx_s5.ay;
			ctx_s6 <= ctx_s5;
			for (int a = 0; a < 2; a++) begin
				ph_s6[a] <= pc[a] * $signed(na_s5[63:32]);
				pl_s6[a] <= pc[a] * $signed({1'b0, na_s5[31:0]});
				qh_s6[a] <= qc[a] * $signed(nb_s5[63:32]);
				ql_s6[a] <= qc[a] * $signed({1'b0, nb_s5[31:0]});
				rb_s6[a] <= pc[a] * $signed({1'b0, ctx_s5.rad});
				ra_s6[a] <= qc[a] * $signed({1'b0, ctx_s5.rad});
			end
		end
	end

	// s7: assemble p*na and q*nb
	ctx_t ctx_s7;
	logic signed [95:0] pp_s7 [2], qq_s7 [2];
	logic signed [63:0] rb_s7 [2], ra_s7 [2];
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s7 <= ctx_s6;
			for (int a = 0; a < 2; a++) begin
				pp_s7[a] <= (96'(ph_s6[a]) <<< 32) + 96'(pl_s6[a]);
				qq_s7[a] <= (96'(qh_s6[a]) <<< 32) + 96'(ql_s6[a]);
				rb_s7[a] <= rb_s6[a];
				ra_s7[a] <= ra_s6[a];
			end
		end
	end

	// s8: common part of the numerator
	ctx_t ctx_s8;
	logic signed [95:0] dd_s8 [2];
	logic signed [63:0] rb_s8 [2], ra_s8 [2];
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s8 <= ctx_s7;
			for (int a = 0; a < 2; a++) begin
				dd_s8[a] <= pp_s7[a] - qq_s7[a];
				rb_s8[a] <= rb_s7[a];
				ra_s8[a] <= ra_s7[a];
			end
		end
	end

	// s9: numerator per candidate, lane = 2*cand + axis
	ctx_t ctx_s9;
	logic signed [95:0] num_s9 [NLANE];
	always_ff @(posedge clk) begin
		logic signed [95:0] rbs;
		logic signed [95:0] ras;
		if (adv) begin
			ctx_s9 <= ctx_s8;
			for (int k = 0; k < NCAND; k++) begin
				for (int a = 0; a < 2; a++) begin
					rbs = 96'(rb_s8[a]) <<< 30;
					ras = 96'(ra_s8[a]) <<< 30;
					num_s9[2*k+a] <= dd_s8[a] + (((k & 2) != 0) ? rbs : -rbs)
						- (((k & 1) != 0) ? ras : -ras);
				end
			end
		end
	end

	// s10: sign and magnitude
	ctx_t ctx_s10;
	logic [94:0] mag_s10 [NLANE];
	logic        neg_s10 [NLANE];
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s10 <= ctx_s9;
			for (int l = 0; l < NLANE; l++) begin
				mag_s10[l] <= num_s9[l][95] ? 95'(-num_s9[l]) : num_s9[l][94:0];
				neg_s10[l] <= num_s9[l][95] ^ ctx_s9.dneg;
			end
		end
	end

	// s11: overflow check against 2^31 and divider seed
	ctx_t ctx_s11;
	logic [61:0] r0_s11 [NLANE];
	logic [30:0] low_s11 [NLANE];
	logic        big_s11 [NLANE];
	logic        neg_s11 [NLANE];
	always_ff @(posedge clk) begin
		logic bg;
		if (adv) begin
			ctx_s11 <= ctx_s10;
			for (int l = 0; l < NLANE; l++) begin
				bg = mag_s10[l][94:31] >= 64'(ctx_s10.dmag);
				big_s11[l] <= bg;
				r0_s11[l] <= bg ? '0 : mag_s10[l][92:31];
				low_s11[l] <= mag_s10[l][30:0];
				neg_s11[l] <= neg_s10[l];
			end
		end
	end

	// -----------------------------------------------------------------------
	// center division, one quotient bit per stage, eight lanes
	// -----------------------------------------------------------------------
	ctx_t        dc_ctx_s [CQ_STEPS];
	logic        dc_v_s   [CQ_STEPS];
	logic [61:0] dc_r_s   [CQ_STEPS][NLANE];
	logic [30:0] dc_q_s   [CQ_STEPS][NLANE];
	logic [30:0] dc_low_s [CQ_STEPS][NLANE];
	logic        dc_big_s [CQ_STEPS][NLANE];
	logic        dc_neg_s [CQ_STEPS][NLANE];

	for (genvar gi = 0; gi < CQ_STEPS; gi++) begin : g_dc
		ctx_t        c_in;
		logic        v_in;
		logic [61:0] r_in [NLANE];
		logic [30:0] q_in [NLANE];
		logic [30:0] low_in [NLANE];
		logic        big_in [NLANE];
		logic        neg_in [NLANE];
		logic [61:0] r_n [NLANE];
		logic [30:0] q_n [NLANE];

		if (gi == 0) begin : g_first
			always_comb begin
				c_in = ctx_s11;
				v_in = v_s11;
				for (int l = 0; l < NLANE; l++) begin
					r_in[l] = r0_s11[l];
					q_in[l] = '0;
					low_in[l] = low_s11[l];
					big_in[l] = big_s11[l];
					neg_in[l] = neg_s11[l];
				end
			end
		end else begin : g_next
			always_comb begin
				c_in = dc_ctx_s[gi-1];
				v_in = dc_v_s[gi-1];
				for (int l = 0; l < NLANE; l++) begin
					r_in[l] = dc_r_s[gi-1][l];
					q_in[l] = dc_q_s[gi-1][l];
					low_in[l] = dc_low_s[gi-1][l];
					big_in[l] = dc_big_s[gi-1][l];
					neg_in[l] = dc_neg_s[gi-1][l];
				end
			end
		end

		always_comb begin
			logic [62:0] r2;
			for (int l = 0; l < NLANE; l++) begin
				r2 = {r_in[l], low_in[l][30]};
				if (r2 >= {1'b0, c_in.dmag}) begin
					r_n[l] = 62'(r2 - {1'b0, c_in.dmag});
					q_n[l] = {q_in[l][29:0], 1'b1};
				end else begin
					r_n[l] = r2[61:0];
					q_n[l] = {q_in[l][29:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dc_v_s[gi] <= 1'b0;
			else if (adv) dc_v_s[gi] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dc_ctx_s[gi] <= c_in;
				for (int l = 0; l < NLANE; l++) begin
					dc_r_s[gi][l] <= r_n[l];
					dc_q_s[gi][l] <= q_n[l];
					dc_low_s[gi][l] <= low_in[l] << 1;
					dc_big_s[gi][l] <= big_in[l];
					dc_neg_s[gi][l] <= neg_in[l];
				end
			end
		end
	end

	// s12: signed, saturated center coordinates
	ctx_t ctx_s12;
	logic signed [31:0] crd_s12 [NLANE];
	always_ff @(posedge clk) begin
		logic [31:0] m;
		logic signed [32:0] ms;
		if (adv) begin
			ctx_s12 <= dc_ctx_s[CQ_STEPS-1];
			for (int l = 0; l < NLANE; l++) begin
				m = dc_big_s[CQ_STEPS-1][l] ? 32'h8000_0000 : {1'b0, dc_q_s[CQ_STEPS-1][l]};
				ms = $signed({1'b0, m});
				if (dc_neg_s[CQ_STEPS-1][l]) crd_s12[l] <= 32'(-ms);
				else crd_s12[l] <= m[31] ? 32'sh7FFF_FFFF : $signed(m);
			end
		end
	end

	// s13: forward test products
	ctx_t ctx_s13;
	logic signed [31:0] crd_s13 [NLANE];
	logic signed [64:0] pa1_s13 [NCAND], pa2_s13 [NCAND], pb1_s13 [NCAND], pb2_s13 [NCAND];
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s13 <= ctx_s12;
			for (int l = 0; l < NLANE; l++) crd_s13[l] <= crd_s12[l];
			for (int k = 0; k < NCAND; k++) begin
				pa1_s13[k] <= ctx_s12.ax * (33'(crd_s12[2*k]) - 33'(ctx_s12.cax));
				pa2_s13[k] <= ctx_s12.ay * (33'(crd_s12[2*k+1]) - 33'(ctx_s12.cay));
				pb1_s13[k] <= ctx_s12.bx * (33'(crd_s12[2*k]) - 33'(ctx_s12.cbx));
				pb2_s13[k] <= ctx_s12.by * (33'(crd_s12[2*k+1]) - 33'(ctx_s12.cby));
			end
		end
	end

	// s14: keep the first candidate forward of the corner on both lines
	ctx_t ctx_n14, ctx_s14;
	always_comb begin
		logic signed [65:0] sa;
		logic signed [65:0] sb;
		logic [NCAND-1:0] pass;
		ctx_n14 = ctx_s13;
		for (int k = 0; k < NCAND; k++) begin
			sa = 66'(pa1_s13[k]) + 66'(pa2_s13[k]);
			sb = 66'(pb1_s13[k]) + 66'(pb2_s13[k]);
			pass[k] = !sa[65] && !sb[65];
		end
		ctx_n14.found = ctx_s13.ok && (pass != '0);
		priority if (pass[0]) begin
			ctx_n14.cx = crd_s13[0];
			ctx_n14.cy = crd_s13[1];
		end else if (pass[1]) begin
			ctx_n14.cx = crd_s13[2];
			ctx_n14.cy = crd_s13[3];
		end else if (pass[2]) begin
			ctx_n14.cx = crd_s13[4];
			ctx_n14.cy = crd_s13[5];
		end else begin
			ctx_n14.cx = crd_s13[6];
			ctx_n14.cy = crd_s13[7];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) ctx_s14 <= ctx_n14;
	end

	// s15: distance-along-normal products
	ctx_t ctx_s15;
	logic signed [64:0] e1_s15, e2_s15, e3_s15, e4_s15;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s15 <= ctx_s14;
			e1_s15 <= ctx_s14.ay * (33'(ctx_s14.cax) - 33'(ctx_s14.cx));
			e2_s15 <= ctx_s14.ax * (33'(ctx_s14.cay) - 33'(ctx_s14.cy));
			e3_s15 <= ctx_s14.by * (33'(ctx_s14.cbx) - 33'(ctx_s14.cx));
			e4_s15 <= ctx_s14.bx * (33'(ctx_s14.cby) - 33'(ctx_s14.cy));
		end
	end

	// s16: rounded Q16 distances
	ctx_t ctx_n16, ctx_s16;
	always_comb begin
		ctx_n16 = ctx_s15;
		ctx_n16.da = 40'(rnd_q30(80'(66'(e2_s15) - 66'(e1_s15))));
		ctx_n16.db = 40'(rnd_q30(80'(66'(e4_s15) - 66'(e3_s15))));
	end

	always_ff @(posedge clk) begin
		if (adv) ctx_s16 <= ctx_n16;
	end

	// s17: normal times distance
	ctx_t ctx_s17;
	logic signed [72:0] f1_s17, f2_s17, f3_s17, f4_s17;
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s17 <= ctx_s16;
			f1_s17 <= (-33'(ctx_s16.ay)) * ctx_s16.da;
			f2_s17 <= 33'(ctx_s16.ax) * ctx_s16.da;
			f3_s17 <= (-33'(ctx_s16.by)) * ctx_s16.db;
			f4_s17 <= 33'(ctx_s16.bx) * ctx_s16.db;
		end
	end

	// s18: tangent points and result register
	result_t res_n18, res_s18;
	always_comb begin
		res_n18 = '0;
		if (!ctx_s17.ok) begin
			res_n18.status = STATUS_DEGEN;
		end else if (!ctx_s17.found) begin
			res_n18.status = STATUS_NONE;
		end else begin
			res_n18.status = STATUS_FOUND;
			res_n18.center_x = ctx_s17.cx;
			res_n18.center_y = ctx_s17.cy;
			res_n18.tangent_a_x = sat32(53'(ctx_s17.cx) + 53'(rnd_q30(80'(f1_s17))));
			res_n18.tangent_a_y = sat32(53'(ctx_s17.cy) + 53'(rnd_q30(80'(f2_s17))));
			res_n18.tangent_b_x = sat32(53'(ctx_s17.cx) + 53'(rnd_q30(80'(f3_s17))));
			res_n18.tangent_b_y = sat32(53'(ctx_s17.cy) + 53'(rnd_q30(80'(f4_s17))));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s18 <= res_n18;
	end

	assign result = res_s18;
	assign result_valid = v_s18;

	// valid bits of the named stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
		end else if (adv) begin
			v_s1 <= query_valid;
			v_s2 <= v_s1;
			v_s3 <= du_v_s[DIR_STEPS-1];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= dc_v_s[CQ_STEPS-1];
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
		end
	end

	// a beat that is not a found center carries zero coordinates
	a_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != STATUS_FOUND |->
			result.center_x == 0 && result.center_y == 0 &&
			result.tangent_a_x == 0 && result.tangent_b_y == 0)
		else $error("non-found result with nonzero coordinates");

	// a held result must back-pressure the query side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !query_ready)
		else $error("query accepted while result stalled");

	// a selected candidate implies sound geometry
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		v_s14 && ctx_s14.found |-> ctx_s14.ok)
		else $error("candidate found on degenerate lines");

	// a stall freezes the last stage's status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s18 && !result_ready |=> v_s18 && $stable(res_s18.status))
		else $error("output stage moved during stall");

endmodule

// ===== test/line_line_fillet_center_top_tb.sv =====
// ---------------------------------------------------------------------------
// line_line_fillet_center_top_tb: fillet center solver testbench
// Drives line-pair queries under random idling on both handshakes and checks
// every result beat against an in-bench fixed-point predictor.
// ---------------------------------------------------------------------------
module line_line_fillet_center_top_tb;
	import llfc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 112;
	localparam int SAT_HI = 32'sh7fffffff;

	logic clk;
	logic arst_n;
	logic query_valid;
	logic query_ready;
	query_t query;
	logic result_valid;
	logic result_ready;
	result_t result;

	line_line_fillet_center_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_ready(query_ready),
		.query(query),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// idle percentages for each side
	int send_idle_pct;
	int recv_idle_pct;

	result_t fillet_expected[$];
	int mismatches;
	int results_seen;
	int found_cnt, none_cnt, degen_cnt;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Timeout");
		$display("Mismatches found");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] mag_of(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Q.46 to Q.16, nearest, ties away from zero
	function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
		logic [63:0] m;
		m = (mag_of(v) + (64'd1 << 29)) >> 30;
		return v < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Q2.30 unit vector; returns 0 for zero length
	function automatic bit normalize(input logic signed [63:0] dx, input logic signed [63:0] dy,
			output logic signed [63:0] ox, output logic signed [63:0] oy);
		logic [63:0] ux, uy, m, len;
		ux = mag_of(dx);
		uy = mag_of(dy);
		m = ux > uy ? ux : uy;
		ox = 0;
		oy = 0;
		if (m == 0) return 0;
		if (m >= (64'd1 << 31)) begin
			ux >>= 1;
			uy >>= 1;
		end else begin
			while (m < (64'd1 << 30)) begin
				m <<= 1;
				ux <<= 1;
				uy <<= 1;
			end
		end
		len = int_sqrt(ux * ux + uy * uy);
		ux = (ux << 30) / len;
		uy = (uy << 30) / len;
		ox = dx < 0 ? -$signed(ux) : $signed(ux);
		oy = dy < 0 ? -$signed(uy) : $signed(uy);
		return 1;
	endfunction

	// one center axis: (p*va - q*vb) / det, truncated, capped, saturated
	function automatic logic signed [63:0] center_axis(logic signed [63:0] p,
			logic signed [63:0] va, logic signed [63:0] q, logic signed [63:0] vb,
			logic signed [63:0] det);
		logic signed [127:0] num;
		logic [127:0] nmag, quo;
		logic [63:0] m;
		bit nneg;
		num = 128'(p) * 128'(va) - 128'(q) * 128'(vb);
		nneg = num < 0;
		nmag = nneg ? -num : num;
		quo = nmag / 128'(mag_of(det));
		m = quo >= (128'd1 << 31) ? (64'd1 << 31) : quo[63:0];
		if (nneg != (det < 0)) return -$signed(m);
		return m > 64'(SAT_HI) ? 64'(SAT_HI) : $signed(m);
	endfunction

	function automatic result_t predict_fillet(query_t qb);
		result_t r;
		logic signed [63:0] cax, cay, cbx, cby, ax, ay, bx, by, det, r46, na, nb;
		logic signed [63:0] va, vb, cx, cy, da, db;
		logic signed [63:0] pax0, pay0, pax1, pay1, pbx0, pby0, pbx1, pby1;
		bit ok_a, ok_b;
		r = '0;
		pax0 = qb.line_a_start_x;
		pay0 = qb.line_a_start_y;
		pax1 = qb.line_a_end_x;
		pay1 = qb.line_a_end_y;
		pbx0 = qb.line_b_start_x;
		pby0 = qb.line_b_start_y;
		pbx1 = qb.line_b_end_x;
		pby1 = qb.line_b_end_y;
		r46 = 64'(qb.fillet_radius) << 30;
		if (qb.a_corner_at_start) begin
			cax = pax0; cay = pay0;
			ok_a = normalize(pax1 - pax0, pay1 - pay0, ax, ay);
		end else begin
			cax = pax1; cay = pay1;
			ok_a = normalize(pax0 - pax1, pay0 - pay1, ax, ay);
		end
		if (qb.b_corner_at_start) begin
			cbx = pbx0; cby = pby0;
			ok_b = normalize(pbx1 - pbx0, pby1 - pby0, bx, by);
		end else begin
			cbx = pbx1; cby = pby1;
			ok_b = normalize(pbx0 - pbx1, pby0 - pby1, bx, by);
		end
		det = (ok_a && ok_b) ? ax * by - ay * bx : 0;
		if (det == 0) begin
			r.status = STATUS_DEGEN;
			return r;
		end
		na = -ay * cax + ax * cay;
		nb = -by * cbx + bx * cby;
		r.status = STATUS_NONE;
		// candidate order (-,-), (-,+), (+,-), (+,+)
		for (int k = 0; k < 4; k++) begin
			va = k[1] ? na + r46 : na - r46;
			vb = k[0] ? nb + r46 : nb - r46;
			cx = center_axis(bx, va, ax, vb, det);
			cy = center_axis(by, va, ay, vb, det);
			if (ax * (cx - cax) + ay * (cy - cay) < 0) continue;
			if (bx * (cx - cbx) + by * (cy - cby) < 0) continue;
			da = round_q30(-ay * (cax - cx) + ax * (cay - cy));
			db = round_q30(-by * (cbx - cx) + bx * (cby - cy));
			r.status = STATUS_FOUND;
			r.center_x = cx[31:0];
			r.center_y = cy[31:0];
			r.tangent_a_x = 32'(clamp32(cx + round_q30(-ay * da)));
			r.tangent_a_y = 32'(clamp32(cy + round_q30(ax * da)));
			r.tangent_b_x = 32'(clamp32(cx + round_q30(-by * db)));
			r.tangent_b_y = 32'(clamp32(cy + round_q30(bx * db)));
			break;
		end
		return r;
	endfunction

	// ---------------- driving ----------------

	// starts and ends at a falling edge; valid drops only while idling
	task automatic send_query(query_t qb);
		while ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 1'b0;
			@(negedge clk);
		end
		query <= qb;
		query_valid <= 1'b1;
		fillet_expected.insert(fillet_expected.size(), predict_fillet(qb));
		@(posedge clk);
		while (!query_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls, redrawn every cycle
	always @(negedge clk) begin
		if (arst_n) result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (fillet_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result beat %p", result);
			end else begin
				exp_r = fillet_expected.pop_front();
				case (exp_r.status)
					STATUS_FOUND: found_cnt++;
					STATUS_NONE: none_cnt++;
					default: degen_cnt++;
				endcase
				if (result.status !== exp_r.status || result.center_x !== exp_r.center_x
						|| result.center_y !== exp_r.center_y
						|| result.tangent_a_x !== exp_r.tangent_a_x
						|| result.tangent_a_y !== exp_r.tangent_a_y
						|| result.tangent_b_x !== exp_r.tangent_b_x
						|| result.tangent_b_y !== exp_r.tangent_b_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d differs: expected %p, got %p",
							results_seen, exp_r, result);
				end
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(200)) - 100) << 16;
			default: return 32'($signed($urandom_range(4000)) - 2000) << 12;
		endcase
	endfunction

	function automatic logic [30:0] rand_radius();
		case ($urandom_range(4))
			0: return 31'($urandom());
			1: return 31'($urandom_range(1 << 20));
			2: return 31'(0);
			default: return 31'($urandom_range(50)) << 16;
		endcase
	endfunction

	// two segments sharing a corner, pointing out at random directions
	function automatic query_t corner_query();
		query_t qb;
		logic [31:0] cx, cy;
		cx = rand_coord();
		cy = rand_coord();
		if ($urandom_range(2) == 0) begin
			cx = $signed(cx) >>> 4;
			cy = $signed(cy) >>> 4;
		end
		qb.a_corner_at_start = 1'($urandom_range(1));
		qb.b_corner_at_start = 1'($urandom_range(1));
		qb.fillet_radius = rand_radius();
		if (qb.a_corner_at_start) begin
			qb.line_a_start_x = cx; qb.line_a_start_y = cy;
			qb.line_a_end_x = cx + (rand_coord() >>> 2);
			qb.line_a_end_y = cy + (rand_coord() >>> 2);
		end else begin
			qb.line_a_end_x = cx; qb.line_a_end_y = cy;
			qb.line_a_start_x = cx + (rand_coord() >>> 2);
			qb.line_a_start_y = cy + (rand_coord() >>> 2);
		end
		if (qb.b_corner_at_start) begin
			qb.line_b_start_x = cx; qb.line_b_start_y = cy;
			qb.line_b_end_x = cx + (rand_coord() >>> 2);
			qb.line_b_end_y = cy + (rand_coord() >>> 2);
		end else begin
			qb.line_b_end_x = cx; qb.line_b_end_y = cy;
			qb.line_b_start_x = cx + (rand_coord() >>> 2);
			qb.line_b_start_y = cy + (rand_coord() >>> 2);
		end
		return qb;
	endfunction

	function automatic query_t raw_query();
		query_t qb;
		qb.line_a_start_x = rand_coord();
		qb.line_a_start_y = rand_coord();
		qb.line_a_end_x = rand_coord();
		qb.line_a_end_y = rand_coord();
		qb.line_b_start_x = rand_coord();
		qb.line_b_start_y = rand_coord();
		qb.line_b_end_x = rand_coord();
		qb.line_b_end_y = rand_coord();
		qb.fillet_radius = rand_radius();
		qb.a_corner_at_start = 1'($urandom_range(1));
		qb.b_corner_at_start = 1'($urandom_range(1));
		return qb;
	endfunction

	function automatic query_t make_query(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1, logic [30:0] rad, bit ca, bit cb);
		query_t qb;
		qb.line_a_start_x = ax0; qb.line_a_start_y = ay0;
		qb.line_a_end_x = ax1; qb.line_a_end_y = ay1;
		qb.line_b_start_x = bx0; qb.line_b_start_y = by0;
		qb.line_b_end_x = bx1; qb.line_b_end_y = by1;
		qb.fillet_radius = rad;
		qb.a_corner_at_start = ca;
		qb.b_corner_at_start = cb;
		return qb;
	endfunction

	// called at a falling edge; drops valid, then waits for every result
	task automatic wait_drained();
		query_valid <= 1'b0;
		while (fillet_expected.size() != 0) @(negedge clk);
	endtask

	// ---------------- tests ----------------

	// hand-picked corners and special cases
	task automatic test_directed();
		localparam int ONE = 1 << 16;
		// right-angle corner at origin, all four corner flag combinations
		send_query(make_query(0, 0, 10*ONE, 0, 0, 0, 0, 10*ONE, 31'(ONE), 1, 1));
		send_query(make_query(10*ONE, 0, 0, 0, 0, 10*ONE, 0, 0, 31'(2*ONE), 0, 0));
		send_query(make_query(0, 0, 10*ONE, 0, 0, 10*ONE, 0, 0, 31'(3*ONE), 1, 0));
		send_query(make_query(10*ONE, 0, 0, 0, 0, 0, 0, 10*ONE, 31'(ONE/2), 0, 1));
		// zero radius: lines' intersection
		send_query(make_query(ONE, ONE, 5*ONE, 3*ONE, ONE, ONE, -2*ONE, 7*ONE, 31'(0), 1, 1));
		// zero-length line A, then B
		send_query(make_query(ONE, ONE, ONE, ONE, 0, 0, ONE, 0, 31'(ONE), 1, 1));
		send_query(make_query(0, 0, ONE, 0, 5, 5, 5, 5, 31'(ONE), 0, 0));
		// parallel and antiparallel
		send_query(make_query(0, 0, ONE, ONE, 0, ONE, 2*ONE, 3*ONE, 31'(ONE), 1, 1));
		send_query(make_query(0, 0, ONE, 0, 0, 0, -ONE, 0, 31'(ONE), 1, 1));
		// huge radius: largest fillet_radius on a right-angle corner
		send_query(make_query(0, 0, ONE, 0, 0, 0, 0, ONE, 31'h7fffffff, 1, 1));
		// nearly parallel lines: the first rounds to parallel unit directions (degenerate), the second saturates
		send_query(make_query(0, 0, 32'h7fffffff, 1, 0, 0, 32'h7fffffff, 0, 31'(ONE), 1, 1));
		send_query(make_query(0, 0, 32'h7fffffff, 3, 0, 0, 32'h7fffffff, 0, 31'h7fffffff, 1, 1));
		// coordinate extremes
		send_query(make_query(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 31'(ONE), 1, 1));
		send_query(make_query(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff, 0, 0));
		send_query(make_query(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h1, 0, 1));
		// tiny segments (shift-up path of the normalizer)
		send_query(make_query(0, 0, 1, 0, 0, 0, 1, 1, 31'(1), 1, 1));
		send_query(make_query(-1, -1, -1, 0, -1, -1, 0, -1, 31'(ONE), 1, 1));
		// obtuse and acute corners
		send_query(make_query(0, 0, 10*ONE, 0, 0, 0, -10*ONE, ONE, 31'(ONE), 1, 1));
		send_query(make_query(0, 0, 10*ONE, 0, 0, 0, 10*ONE, ONE, 31'(ONE/4), 1, 1));
		send_query(make_query(0, 0, 10*ONE, 0, 0, 0, 10*ONE, -ONE, 31'(ONE/4), 1, 1));
	endtask

	// mostly proper corners, some raw noise
	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75) send_query(corner_query());
			else send_query(raw_query());
			// one hold-off until the pipe is empty
			if (i == count / 2) wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		result_ready = 1'b0;
		send_idle_pct = 35;
		recv_idle_pct = 71;
		mismatches = 0;
		results_seen = 0;
		found_cnt = 0;
		none_cnt = 0;
		degen_cnt = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(400);
		send_idle_pct = 71;
		recv_idle_pct = 35;
		test_random(400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(400);

		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);

		$display("Checked %0d results: %0d centers found, %0d without candidate, %0d degenerate",
			results_seen, found_cnt, none_cnt, degen_cnt);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching results", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
